### rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("assertion failed");
// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### rtl/nsr_pkg.sv
// shared constants and types of the noise-to-signal ratio block
package nsr_pkg;

	localparam int PRICE_W        = 32;
	localparam int RATIO_W        = 16;
	localparam int WLEN_W         = 9;
	localparam int MAX_WINDOW_DEF = 256;
	localparam int DEFAULT_WINDOW = 64;

	// quotient format: integer bits hold up to 10, then the fraction
	localparam int INT_BITS   = 4;
	localparam int FRAC_BITS  = 12;
	localparam int DIV_STEPS  = INT_BITS + FRAC_BITS;
	localparam int FULL_SCALE = 10 << FRAC_BITS;

	localparam int PATH_W_DEF = PRICE_W + $clog2(MAX_WINDOW_DEF);

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

### rtl/nsr_ring.sv
// price history memory, one write and one registered read port
module nsr_ring #(
	parameter int DEPTH = nsr_pkg::MAX_WINDOW_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [AW-1:0]                wr_addr,
	input  logic [nsr_pkg::PRICE_W-1:0]  wr_data,
	input  logic [AW-1:0]                rd_addr,
	output logic [nsr_pkg::PRICE_W-1:0]  rd_data
);

	logic [nsr_pkg::PRICE_W-1:0] mem [DEPTH];
	logic [nsr_pkg::PRICE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/nsr_div.sv
// radix-2 digit recurrence divider, one quotient bit per cycle
`include "assert_macros.svh"

module nsr_div #(
	parameter int PW = nsr_pkg::PATH_W_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [PW-1:0]                diff,
	input  logic [PW-1:0]                den,
	output nsr_pkg::div_sts_t            sts,
	output logic [nsr_pkg::RATIO_W-1:0]  quo
);

	localparam int RW = PW + nsr_pkg::INT_BITS;
	localparam int CW = $clog2(nsr_pkg::DIV_STEPS);
	localparam int QW = nsr_pkg::RATIO_W;

	logic [RW-1:0] rem_q;
	logic [RW-1:0] den_sh;
	logic [RW-1:0] rem_sub;
	logic [RW-1:0] scaled;
	logic          ge;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	// dividend times 10 as 8x plus 2x
	assign scaled  = (RW'(diff) << 3) + (RW'(diff) << 1);
	// first digit has weight 8
	assign den_sh  = RW'(den) << (nsr_pkg::INT_BITS - 1);
	assign ge      = rem_q >= den_sh;
	assign rem_sub = rem_q - den_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(nsr_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= scaled;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sub << 1) : (rem_q << 1);
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quo      = quo_q;

	`ASSERT_PROP(a_rem_bound, clk, arst_n, busy_q |-> (rem_q < (RW'(den) << nsr_pkg::INT_BITS)))
	`ASSERT_NEVER(a_start_while_busy, clk, arst_n, start && busy_q)
	`ASSERT_PROP(a_done_pulse, clk, arst_n, done_q |=> !done_q)

endmodule

### rtl/windowed_noise_to_signal_ratio.sv
// top level of the windowed noise-to-signal ratio block
//
// usage
//   s_t* carries one closing price per item, m_t* one ratio item back, cfg_* writes the
//   window length. a window write clears the price history, path sum and sample count.
//   a window write offered together with a price goes first; s_tready stays low then.
//   the first two prices after reset or a window write give no result item; every
//   later price gives exactly one.
// sequencing
//   a price that gives a result reaches m_tvalid as the sequencer returns to idle, and
//   s_tready comes back in that same cycle; the next price waits until then. the 16-step
//   divider sets most of the time, the three reads through the one read port of the history
//   memory the rest. a flat path skips the divider; a price with no result goes from the
//   ring write straight back to idle.
// reset
//   arst_n clears control state; window length returns to 64. the history memory is not
//   cleared: no entry is used before it was written.
// stalls
//   the result sits in an output register while m_tready is low; the next finished
//   result waits in the sequencer and no further price is taken until it is handed over.
`include "assert_macros.svh"

module windowed_noise_to_signal_ratio #(
	parameter int MAX_WINDOW = nsr_pkg::MAX_WINDOW_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// price stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [nsr_pkg::PRICE_W-1:0]  s_tdata,   // [31:0] price
	// ratio stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [nsr_pkg::RATIO_W-1:0]  m_tdata,   // [15:0] ratio_scaled
	// window length register
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [nsr_pkg::WLEN_W-1:0]   cfg_data   // [8:0] window_length
);

	localparam int AW = $clog2(MAX_WINDOW);
	localparam int NW = $clog2(MAX_WINDOW + 1);
	localparam int SW = $clog2(MAX_WINDOW + 3);
	localparam int PW = nsr_pkg::PRICE_W + AW;
	localparam int WW = (NW > nsr_pkg::WLEN_W) ? NW : nsr_pkg::WLEN_W;
	localparam int DW = nsr_pkg::PRICE_W;
	localparam int QW = nsr_pkg::RATIO_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_DROP,
		ST_PREP,
		ST_DIFF,
		ST_START,
		ST_DIV,
		ST_EMIT
	} state_t;

	function automatic logic [DW-1:0] abs_diff(input logic [DW-1:0] a, input logic [DW-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// control state
	state_t                    state_q;
	logic [nsr_pkg::WLEN_W-1:0] wl_q;
	logic [AW-1:0]             wp_q;
	logic [SW-1:0]             samples_q;
	logic [PW-1:0]             path_q;
	logic                      drop_q;
	logic                      zero_q;
	logic                      m_tvalid_q;
	logic [QW-1:0]             m_tdata_q;

	// per-item payload
	logic [DW-1:0]             price_q;
	logic [DW-1:0]             drift_q;
	logic [DW-1:0]             old_q;
	logic [DW-1:0]             step_q;
	logic [PW-1:0]             diff_q;

	// derived
	logic [WW-1:0]             n_ext;
	logic [NW-1:0]             win_n;
	logic [NW-1:0]             drift_back;
	logic [NW-1:0]             back;
	logic [AW:0]               slot_raw;
	logic [AW:0]               slot_wrap;
	logic [AW-1:0]             rd_addr;
	logic [DW-1:0]             rd_data;
	logic                      in_acc;
	logic                      div_start;
	nsr_pkg::div_sts_t         div_sts;
	logic [QW-1:0]             div_quo;
	logic [QW-1:0]             ratio_val;

	// effective window: short values fall back to the default, long ones saturate
	always_comb begin
		n_ext = WW'(wl_q);
		if (n_ext < WW'(2)) begin
			n_ext = WW'(nsr_pkg::DEFAULT_WINDOW);
		end
		if (n_ext > WW'(MAX_WINDOW)) begin
			n_ext = WW'(MAX_WINDOW);
		end
		win_n = n_ext[NW-1:0];
	end

	// oldest window price: while history is young it is the second price received
	assign drift_back = (samples_q >= SW'(win_n)) ? (win_n - NW'(1))
	                                               : NW'(samples_q - SW'(1));

	// which slot behind the write pointer each read state fetches
	always_comb begin
		case (state_q)
			ST_RD1:  back = NW'(1);
			ST_RD2:  back = drift_back;
			ST_RD3:  back = win_n;
			default: back = NW'(1);
		endcase
	end

	// wp minus back, modulo the memory depth (back never exceeds the depth)
	assign slot_raw  = {1'b0, wp_q} + (AW+1)'(MAX_WINDOW) - (AW+1)'(back);
	assign slot_wrap = (slot_raw >= (AW+1)'(MAX_WINDOW)) ? (slot_raw - (AW+1)'(MAX_WINDOW))
	                                                    : slot_raw;
	assign rd_addr   = slot_wrap[AW-1:0];

	// a pending window write takes the idle slot ahead of a price
	assign s_tready  = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign div_start = (state_q == ST_START);

	// quotient cannot pass full scale, the clamp only guards it
	always_comb begin
		if (zero_q) begin
			ratio_val = '0;
		end else if (div_quo > QW'(nsr_pkg::FULL_SCALE)) begin
			ratio_val = QW'(nsr_pkg::FULL_SCALE);
		end else begin
			ratio_val = div_quo;
		end
	end

	nsr_ring #(
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk     (clk),
		.wr_en   (state_q == ST_DROP),
		.wr_addr (wp_q),
		.wr_data (price_q),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	nsr_div #(
		.PW(PW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.diff   (diff_q),
		.den    (path_q),
		.sts    (div_sts),
		.quo    (div_quo)
	);

	// sequencer, history counters and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wl_q       <= nsr_pkg::WLEN_W'(nsr_pkg::DEFAULT_WINDOW);
			wp_q       <= '0;
			samples_q  <= '0;
			path_q     <= '0;
			drop_q     <= 1'b0;
			zero_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// emit state reloads the output register itself
			if (m_tvalid_q && m_tready && (state_q != ST_EMIT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						// new window length restarts the history
						wl_q      <= cfg_data;
						wp_q      <= '0;
						samples_q <= '0;
						path_q    <= '0;
					end else if (in_acc) begin
						state_q <= (samples_q >= SW'(2)) ? ST_RD1 : ST_DROP;
					end
				end
				ST_RD1: begin
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					// newest step joins the path
					path_q  <= path_q + PW'(abs_diff(price_q, rd_data));
					state_q <= ST_RD3;
				end
				ST_RD3: begin
					state_q <= ST_DROP;
				end
				ST_DROP: begin
					// price goes into the ring this cycle
					wp_q <= (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : (wp_q + AW'(1));
					if (samples_q < (SW'(win_n) + SW'(2))) begin
						samples_q <= samples_q + SW'(1);
					end
					drop_q  <= samples_q >= (SW'(win_n) + SW'(1));
					state_q <= (samples_q >= SW'(2)) ? ST_PREP : ST_IDLE;
				end
				ST_PREP: begin
					// step that left the window
					if (drop_q) begin
						path_q <= path_q - PW'(step_q);
					end
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					zero_q  <= (path_q == '0);
					state_q <= (path_q == '0) ? ST_EMIT : ST_START;
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_sts.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= ratio_val;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-item datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			price_q <= s_tdata;
		end
		if (state_q == ST_RD3) begin
			// oldest window price arrives, also the newer end of the leaving step
			drift_q <= abs_diff(price_q, rd_data);
			old_q   <= rd_data;
		end
		if (state_q == ST_DROP) begin
			step_q <= abs_diff(old_q, rd_data);
		end
		if (state_q == ST_DIFF) begin
			diff_q <= path_q - PW'(drift_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`ASSERT_PROP(a_out_range, clk, arst_n, m_tvalid |-> (m_tdata <= QW'(nsr_pkg::FULL_SCALE)))
	`ASSERT_PROP(a_ready_div_idle, clk, arst_n, s_tready |-> !div_sts.busy)
	`ASSERT_PROP(a_drift_le_path, clk, arst_n, (state_q == ST_DIFF) |-> (PW'(drift_q) <= path_q))
	`ASSERT_PROP(a_samples_sat, clk, arst_n, samples_q <= (SW'(win_n) + SW'(2)))

endmodule

### tb/tb_windowed_noise_to_signal_ratio.sv
// self-checking testbench of the windowed noise-to-signal ratio block
module tb_windowed_noise_to_signal_ratio;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HIST_DEPTH = nsr_pkg::MAX_WINDOW_DEF;
	localparam int SLOT_W     = $clog2(HIST_DEPTH);
	localparam int PRICE_W    = nsr_pkg::PRICE_W;
	localparam int RATIO_W    = nsr_pkg::RATIO_W;
	localparam int WLEN_W     = nsr_pkg::WLEN_W;
	localparam int SETTLE     = 40;
	localparam int LONG_HOLD  = 400;
	localparam int TARGET     = 1250;

	// running model of the ratio stream: price history, path sum and the ratios owed
	class nsr_ratio_scoreboard;
		logic [PRICE_W-1:0] hist[HIST_DEPTH];
		logic [SLOT_W-1:0]  slot;
		int unsigned        seen;
		longint unsigned    path;
		logic [WLEN_W-1:0]  wlen;
		logic [RATIO_W-1:0] ratio_q[$];
		int unsigned        mismatches;

		function new();
			wlen       = WLEN_W'(nsr_pkg::DEFAULT_WINDOW);
			mismatches = 0;
			set_window(wlen);
		endfunction

		// a window write also wipes the history
		function void set_window(logic [WLEN_W-1:0] v);
			wlen = v;
			slot = '0;
			seen = 0;
			path = 0;
		endfunction

		function int unsigned span();
			int unsigned n;
			n = wlen;
			if (n < 2) n = nsr_pkg::DEFAULT_WINDOW;
			if (n > HIST_DEPTH) n = HIST_DEPTH;
			return n;
		endfunction

		function logic [PRICE_W-1:0] absdiff(logic [PRICE_W-1:0] a, logic [PRICE_W-1:0] b);
			return (a > b) ? a - b : b - a;
		endfunction

		// price stored k items before the slot about to be written
		function logic [PRICE_W-1:0] back(int unsigned k);
			logic [SLOT_W-1:0] i;
			i = slot - SLOT_W'(k);
			return hist[i];
		endfunction

		function void note_price(logic [PRICE_W-1:0] p);
			int unsigned     n;
			int unsigned     idx;
			int unsigned     drift_back;
			longint unsigned drift;
			longint unsigned full;
			longint unsigned ratio;
			n     = span();
			idx   = seen;
			full  = nsr_pkg::FULL_SCALE;
			ratio = 0;
			if (idx >= 2) begin
				path += absdiff(p, back(1));
				// the oldest step falls out once the window is full
				if (idx >= n + 1) path -= absdiff(back(n - 1), back(n));
				drift_back = (idx >= n) ? n - 1 : idx - 1;
				drift = absdiff(p, back(drift_back));
				if (path != 0) begin
					ratio = (full * (path - drift)) / path;
					if (ratio > full) ratio = full;
				end
				ratio_q.push_back(ratio[RATIO_W-1:0]);
			end
			hist[slot] = p;
			slot++;
			if (seen < n + 2) seen++;
		endfunction

		function void check_ratio(logic [RATIO_W-1:0] got);
			logic [RATIO_W-1:0] want;
			if (ratio_q.size() == 0) begin
				$error("ratio_scaled: unexpected item, actual %0d", got);
				mismatches++;
			end else begin
				want = ratio_q.pop_front();
				if (got !== want) begin
					$error("ratio_scaled mismatch: expected %0d, actual %0d", want, got);
					mismatches++;
				end
			end
		endfunction

		function int pending();
			return ratio_q.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [PRICE_W-1:0]  s_tdata;   // [31:0] price
	logic                m_tvalid;
	logic                m_tready;
	logic [RATIO_W-1:0]  m_tdata;   // [15:0] ratio_scaled
	logic                cfg_valid;
	logic                cfg_ready;
	logic [WLEN_W-1:0]   cfg_data;  // [8:0] window_length

	nsr_ratio_scoreboard ratios = new();

	// idling is switched off for the closing stretch
	bit calm = 1'b0;
	// asks the sink for one long hold-off so the block backs up into its input
	bit long_hold_req = 1'b0;

	windowed_noise_to_signal_ratio i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	// sink side: random stalls, plus one long hold-off on request
	initial begin : ratio_sink
		int hold_left;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				hold_left--;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				hold_left = $urandom_range(1, 9);
			end
			m_tready <= (hold_left == 0);
		end
	end

	// every ratio item taken is checked against the oldest one owed
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) ratios.check_ratio(m_tdata);
	end

	// offer one price, with an optional idle burst ahead of it
	task automatic send_price(input logic [PRICE_W-1:0] p);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 9);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= p;
		do @(posedge clk); while (!s_tready);
		ratios.note_price(p);
	endtask

	// waits until the block is idle: nothing owed and the last price settled
	task automatic write_window(input logic [WLEN_W-1:0] v);
		while (ratios.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ratios.set_window(v);
	endtask

	// mostly a small random walk, with flat stretches, extremes and wild jumps
	function automatic logic [PRICE_W-1:0] next_price(input logic [PRICE_W-1:0] prev);
		int unsigned pick;
		pick = $urandom_range(0, 31);
		if (pick == 0) return '0;
		if (pick == 1) return '1;
		if (pick < 7) return prev;
		if (pick < 10) return $urandom;
		return prev + PRICE_W'($urandom_range(0, 2000)) - PRICE_W'(1000);
	endfunction

	task automatic run_prices(input int count, inout logic [PRICE_W-1:0] p, inout int sent);
		for (int i = 0; i < count; i++) begin
			p = next_price(p);
			send_price(p);
			sent++;
		end
		s_tvalid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [PRICE_W-1:0] opening[$];
		logic [PRICE_W-1:0] p;
		int                 sent;
		opening = '{32'hFFFF_FFFF, 32'd5, 32'd5, 32'd5, 32'd6, 32'd4,
			32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd100,
			32'd200, 32'd300, 32'd250, 32'hA5A5_5A5A, 32'h5A5A_A5A5};
		sent = 0;
		p    = 32'h8000_0000;

		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default window of 64: first price excluded, flat path, extreme steps
		foreach (opening[i]) begin
			send_price(opening[i]);
			sent++;
		end
		s_tvalid <= 1'b0;

		// narrowest window, then the all-ones and all-zeros register values
		write_window(9'd2);
		run_prices(60, p, sent);
		write_window(9'd511);
		run_prices(320, p, sent);
		write_window(9'd0);
		long_hold_req = 1'b1;
		run_prices(70, p, sent);
		write_window(9'd1);
		run_prices(20, p, sent);
		write_window(9'd256);
		run_prices(40, p, sent);
		write_window(9'd3);
		run_prices(60, p, sent);
		write_window(9'd257);
		run_prices(20, p, sent);

		// random windows, mostly short so the window fills and slides often
		while (sent < TARGET - 100) begin
			if ($urandom_range(0, 4) == 0) write_window(WLEN_W'($urandom_range(0, 511)));
			else write_window(WLEN_W'($urandom_range(2, 24)));
			run_prices($urandom_range(30, 90), p, sent);
		end

		// closing stretch at full speed on both sides
		write_window(WLEN_W'($urandom_range(2, 16)));
		calm = 1'b1;
		run_prices(100, p, sent);

		while (ratios.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (ratios.mismatches == 0 && ratios.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/nsr_pkg.sv
rtl/nsr_ring.sv
rtl/nsr_div.sv
rtl/windowed_noise_to_signal_ratio.sv
tb/tb_windowed_noise_to_signal_ratio.sv
